// File: design/qme_pkg.sv
// ----------------------------------------------------------------------------
// qme_pkg
// shared types and constants of the queue machine execute core
// ----------------------------------------------------------------------------
package qme_pkg;

  localparam int unsigned QueueDepth   = 1024;
  localparam int unsigned QueueAw      = $clog2(QueueDepth);
  localparam int unsigned QueueCw      = QueueAw + 1;
  localparam int unsigned ProgramDepth = 65536;
  localparam int unsigned ProgramAw    = (ProgramDepth > 1) ? $clog2(ProgramDepth) : 1;
  localparam int unsigned RegCount     = 26;
  localparam int unsigned RegAw        = 5;
  localparam int unsigned DataW        = 16;

  typedef enum logic [3:0] {
    OpPush     = 4'd0,
    OpAdd      = 4'd1,
    OpSub      = 4'd2,
    OpMul      = 4'd3,
    OpDiv      = 4'd4,
    OpMod      = 4'd5,
    OpStore    = 4'd6,
    OpLoad     = 4'd7,
    OpPrintNum = 4'd8,
    OpPrintChr = 4'd9,
    OpNop      = 4'd10,
    OpJump     = 4'd11,
    OpJz       = 4'd12,
    OpJe       = 4'd13,
    OpJg       = 4'd14,
    OpQuit     = 4'd15
  } op_e;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StUnder = 2'd1;
  localparam logic [1:0] StOver  = 2'd2;

  localparam logic [1:0] PrNone = 2'd0;
  localparam logic [1:0] PrNum  = 2'd1;
  localparam logic [1:0] PrChr  = 2'd2;

  // divider control between sequencer and divider
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
  } div_rsp_t;

endpackage

// File: design/queue_machine_execute_core.sv
// ----------------------------------------------------------------------------
// queue_machine_execute_core
// executes one decoded queue machine instruction per input transaction
// ----------------------------------------------------------------------------
// The input channel carries one decoded instruction (mode, immediate,
// register indexes, print source, resolved target). The output channel
// returns one result transaction per instruction: print kind and value,
// branch decision and target, halt and queue status.
// One instruction is worked on at a time. The queue lives in a single port
// synchronous ram, so each pop goes through a registered read and a push a write.
// Every instruction ends in a done state that registers the result. Push and
// load add a queue write; store and print from the queue add a pop; add, sub,
// mul, div and mod pop two operands, compute and push the result, and div and
// mod by a nonzero divisor also wait for the 16-step iterative divider.
// The result sits in an output register; the next instruction is taken
// once that register is free, so a stalled receiver stops intake.
// Reset clears the register file, the queue pointers and count; queue ram
// contents stay undefined and are only read after being pushed.
// ----------------------------------------------------------------------------
module queue_machine_execute_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  mode_i,
  input  logic [15:0] immediate_i,
  input  logic [4:0]  first_reg_i,
  input  logic [4:0]  second_reg_i,
  input  logic        from_queue_i,
  input  logic [15:0] target_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  print_kind_o,
  output logic [15:0] print_value_o,
  output logic        branch_taken_o,
  output logic [15:0] branch_target_o,
  output logic        halt_o,
  output logic [1:0]  status_o
);

  localparam int unsigned W  = qme_pkg::DataW;
  localparam int unsigned Aw = qme_pkg::QueueAw;
  localparam int unsigned Cw = qme_pkg::QueueCw;

  typedef enum logic [2:0] {
    SIdle, SPop, SPopWait, SCalc, SDivWait, SPush, SDone
  } state_e;

  state_e         state_q;
  qme_pkg::op_e   op_q;
  logic [4:0]     r1_q;
  logic           npop_q;  // one more pop after the current one
  logic           second_q;
  logic [W-1:0]   a_q;
  logic [W-1:0]   b_q;
  logic [W-1:0]   val_q;
  logic [1:0]     st_q;

  logic [W-1:0]   regs_q [qme_pkg::RegCount];
  logic [Aw-1:0]  head_q;
  logic [Aw-1:0]  tail_q;
  logic [Cw-1:0]  count_q;

  logic           ram_we;
  logic [Aw-1:0]  ram_addr;
  logic [W-1:0]   ram_rdata;

  qme_pkg::div_req_t div_req;
  qme_pkg::div_rsp_t div_rsp;

  logic [W-1:0]   r1_val;
  logic [W-1:0]   r2_val;
  logic [W-1:0]   prod;
  logic [W-1:0]   pop_val;
  logic           br_taken;

  assign r1_val = (first_reg_i < 5'(qme_pkg::RegCount)) ? regs_q[first_reg_i] : '0;
  assign r2_val = (second_reg_i < 5'(qme_pkg::RegCount)) ? regs_q[second_reg_i] : '0;
  assign prod   = W'(32'(a_q) * 32'(b_q));

  // branch decision of the incoming instruction
  always_comb begin
    unique case (qme_pkg::op_e'(mode_i))
      qme_pkg::OpJump: br_taken = 1'b1;
      qme_pkg::OpJz:   br_taken = (r1_val == '0);
      qme_pkg::OpJe:   br_taken = (r1_val == r2_val);
      qme_pkg::OpJg:   br_taken = (r1_val > r2_val);
      default:         br_taken = 1'b0;
    endcase
  end

  assign ram_we   = (state_q == SPush) && (count_q != Cw'(qme_pkg::QueueDepth));
  assign ram_addr = (state_q == SPush) ? tail_q : head_q;

  qme_ram #(.Width(W), .Depth(qme_pkg::QueueDepth)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (val_q),
    .rdata_o (ram_rdata)
  );

  assign div_req.start    = (state_q == SCalc) &&
                            ((op_q == qme_pkg::OpDiv) || (op_q == qme_pkg::OpMod)) &&
                            (b_q != '0);
  assign div_req.dividend = a_q;
  assign div_req.divisor  = b_q;

  qme_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == SIdle) && !out_valid_o;
  assign pop_val    = ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= SIdle;
      head_q          <= '0;
      tail_q          <= '0;
      count_q         <= '0;
      out_valid_o     <= 1'b0;
      for (int i = 0; i < qme_pkg::RegCount; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (in_valid_i && in_ready_o) begin
            op_q            <= qme_pkg::op_e'(mode_i);
            r1_q            <= first_reg_i;
            st_q            <= qme_pkg::StOk;
            second_q        <= 1'b0;
            a_q             <= '0;
            b_q             <= '0;
            print_kind_o    <= qme_pkg::PrNone;
            print_value_o   <= '0;
            branch_taken_o  <= br_taken;
            branch_target_o <= br_taken ? 16'(target_i[qme_pkg::ProgramAw-1:0]) : '0;
            halt_o          <= (mode_i == qme_pkg::OpQuit);
            unique case (qme_pkg::op_e'(mode_i))
              qme_pkg::OpPush: begin
                val_q   <= immediate_i;
                state_q <= SPush;
              end
              qme_pkg::OpLoad: begin
                val_q   <= r1_val;
                state_q <= SPush;
              end
              qme_pkg::OpAdd, qme_pkg::OpSub, qme_pkg::OpMul,
              qme_pkg::OpDiv, qme_pkg::OpMod: begin
                npop_q  <= 1'b1;
                state_q <= SPop;
              end
              qme_pkg::OpStore: begin
                npop_q  <= 1'b0;
                state_q <= SPop;
              end
              qme_pkg::OpPrintNum, qme_pkg::OpPrintChr: begin
                if (from_queue_i) begin
                  npop_q  <= 1'b0;
                  state_q <= SPop;
                end else begin
                  val_q   <= r1_val;
                  state_q <= SDone;
                end
              end
              default: state_q <= SDone;
            endcase
          end
        end
        SPop: begin
          if (count_q == '0) begin
            st_q <= qme_pkg::StUnder;
            if (second_q) b_q <= '0; else a_q <= '0;
            val_q <= '0;
            if (npop_q) begin
              npop_q   <= 1'b0;
              second_q <= 1'b1;
            end else begin
              state_q <= SCalc;
            end
          end else begin
            head_q  <= (head_q == Aw'(qme_pkg::QueueDepth - 1)) ? '0 : head_q + Aw'(1);
            count_q <= count_q - Cw'(1);
            state_q <= SPopWait;
          end
        end
        SPopWait: begin
          if (second_q) b_q <= pop_val; else a_q <= pop_val;
          val_q <= pop_val;
          if (npop_q) begin
            npop_q   <= 1'b0;
            second_q <= 1'b1;
            state_q  <= SPop;
          end else begin
            state_q <= SCalc;
          end
        end
        SCalc: begin
          unique case (op_q)
            qme_pkg::OpAdd: begin val_q <= a_q + b_q; state_q <= SPush; end
            qme_pkg::OpSub: begin val_q <= a_q - b_q; state_q <= SPush; end
            qme_pkg::OpMul: begin val_q <= prod;      state_q <= SPush; end
            qme_pkg::OpDiv, qme_pkg::OpMod: begin
              if (b_q == '0) begin
                val_q   <= '0;
                state_q <= SPush;
              end else begin
                state_q <= SDivWait;
              end
            end
            qme_pkg::OpStore: begin
              if (r1_q < 5'(qme_pkg::RegCount)) regs_q[r1_q] <= val_q;
              state_q <= SDone;
            end
            default: state_q <= SDone;
          endcase
        end
        SDivWait: begin
          if (div_rsp.done) begin
            val_q   <= (op_q == qme_pkg::OpDiv) ? div_rsp.quotient : div_rsp.remainder;
            state_q <= SPush;
          end
        end
        SPush: begin
          if (count_q == Cw'(qme_pkg::QueueDepth)) begin
            if (st_q == qme_pkg::StOk) st_q <= qme_pkg::StOver;
          end else begin
            tail_q  <= (tail_q == Aw'(qme_pkg::QueueDepth - 1)) ? '0 : tail_q + Aw'(1);
            count_q <= count_q + Cw'(1);
          end
          state_q <= SDone;
        end
        SDone: begin
          if (op_q == qme_pkg::OpPrintNum) begin
            print_kind_o  <= qme_pkg::PrNum;
            print_value_o <= val_q;
          end else if (op_q == qme_pkg::OpPrintChr) begin
            print_kind_o  <= qme_pkg::PrChr;
            print_value_o <= {8'd0, val_q[7:0]};
          end
          out_valid_o <= 1'b1;
          state_q     <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign status_o = st_q;

endmodule

// File: design/qme_ram.sv
// ----------------------------------------------------------------------------
// qme_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module qme_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  parameter int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: design/qme_div.sv
// ----------------------------------------------------------------------------
// qme_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module qme_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qme_pkg::div_req_t req_i,
  output qme_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W  = qme_pkg::DataW;
  localparam int unsigned Cw = $clog2(W + 1);

  logic [W-1:0]  quo_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  dvs_q;
  logic [Cw-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [W:0]    trial;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= Cw'(W);
        quo_q  <= req_i.dividend;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        if (!trial[W]) begin
          rem_q <= trial[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[W-2:0], quo_q[W-1]};
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - Cw'(1);
        if (cnt_q == Cw'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: design/qme_checker.sv
// ----------------------------------------------------------------------------
// qme_checker
// port level checks of the queue machine execute core
// ----------------------------------------------------------------------------
module qme_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  print_kind_o,
  input logic        branch_taken_o,
  input logic [15:0] branch_target_o,
  input logic        halt_o,
  input logic [1:0]  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result changed while stalled");

  a_no_intake_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("intake while result pending");

  a_untaken_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !branch_taken_o |-> branch_target_o == 16'd0)
    else $error("target without branch");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({halt_o, branch_taken_o, print_kind_o != 2'd0}) <= 1)
    else $error("conflicting result effects");

endmodule

bind queue_machine_execute_core qme_checker u_qme_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .print_kind_o    (print_kind_o),
  .branch_taken_o  (branch_taken_o),
  .branch_target_o (branch_target_o),
  .halt_o          (halt_o),
  .status_o        (status_o)
);

// File: tb/sv/tb_queue_machine_execute_core.sv
// ----------------------------------------------------------------------------
// tb_queue_machine_execute_core
// self-checking bench for the queue machine execute core
// ----------------------------------------------------------------------------
// Drives decoded instructions through the valid/ready input channel. A
// behavioral model of the register file and value queue predicts every
// result transaction, and a monitor compares them in order. The tests are
// directed corner cases, random programs that are mostly well-formed
// push/compute/print/branch runs, and queue fill to overflow. The sender
// works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_queue_machine_execute_core;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pval;
    logic        taken;
    logic [15:0] tgt;
    logic        halt;
    logic [1:0]  st;
  } exec_res_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [3:0]  mode;
  logic [15:0] immediate, target;
  logic [4:0]  first_reg, second_reg;
  logic        from_queue;
  logic [1:0]  print_kind, status;
  logic [15:0] print_value, branch_target;
  logic        branch_taken, halt;

  logic [15:0] regs_m [qme_pkg::RegCount];
  logic [15:0] fifo_m [$];
  logic [1:0]  step_st;
  exec_res_t   expected_q [$];
  int unsigned mismatches, n_results, n_sent, cycles;
  bit          stall_busy;

  queue_machine_execute_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .immediate_i(immediate), .first_reg_i(first_reg),
    .second_reg_i(second_reg), .from_queue_i(from_queue), .target_i(target),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .print_kind_o(print_kind), .print_value_o(print_value),
    .branch_taken_o(branch_taken), .branch_target_o(branch_target),
    .halt_o(halt), .status_o(status)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic logic [15:0] fifo_pop();
    if (fifo_m.size() == 0) begin
      step_st = qme_pkg::StUnder;
      return 16'd0;
    end
    return fifo_m.pop_front();
  endfunction

  function automatic void fifo_push(logic [15:0] v);
    if (fifo_m.size() >= qme_pkg::QueueDepth) begin
      if (step_st == qme_pkg::StOk) step_st = qme_pkg::StOver;
    end else fifo_m.push_back(v);
  endfunction

  function automatic logic [15:0] reg_rd(logic [4:0] idx);
    return (idx < qme_pkg::RegCount) ? regs_m[idx] : 16'd0;
  endfunction

  function automatic exec_res_t execute_instr(qme_pkg::op_e op, logic [15:0] imm,
                                              logic [4:0] r1, logic [4:0] r2,
                                              logic fq, logic [15:0] tg);
    exec_res_t   r;
    logic [15:0] a, b, v;
    r = '0;
    step_st = qme_pkg::StOk;
    case (op)
      qme_pkg::OpPush: fifo_push(imm);
      qme_pkg::OpAdd, qme_pkg::OpSub, qme_pkg::OpMul, qme_pkg::OpDiv,
      qme_pkg::OpMod: begin
        a = fifo_pop();
        b = fifo_pop();
        case (op)
          qme_pkg::OpAdd: v = a + b;
          qme_pkg::OpSub: v = a - b;
          qme_pkg::OpMul: v = a * b;
          qme_pkg::OpDiv: v = (b == 0) ? 16'd0 : a / b;
          default:        v = (b == 0) ? 16'd0 : a % b;
        endcase
        fifo_push(v);
      end
      qme_pkg::OpStore: begin
        v = fifo_pop();
        if (r1 < qme_pkg::RegCount) regs_m[r1] = v;
      end
      qme_pkg::OpLoad: fifo_push(reg_rd(r1));
      qme_pkg::OpPrintNum, qme_pkg::OpPrintChr: begin
        v = fq ? fifo_pop() : reg_rd(r1);
        r.kind = (op == qme_pkg::OpPrintNum) ? qme_pkg::PrNum : qme_pkg::PrChr;
        r.pval = (op == qme_pkg::OpPrintNum) ? v : {8'd0, v[7:0]};
      end
      qme_pkg::OpJump: r.taken = 1'b1;
      qme_pkg::OpJz:   r.taken = (reg_rd(r1) == 0);
      qme_pkg::OpJe:   r.taken = (reg_rd(r1) == reg_rd(r2));
      qme_pkg::OpJg:   r.taken = (reg_rd(r1) > reg_rd(r2));
      qme_pkg::OpQuit: r.halt = 1'b1;
      default: ;
    endcase
    if (r.taken) r.tgt = 16'(tg % qme_pkg::ProgramDepth);
    r.st = step_st;
    return r;
  endfunction

  task automatic send_instr(qme_pkg::op_e op, logic [15:0] imm = '0, logic [4:0] r1 = '0,
                            logic [4:0] r2 = '0, logic fq = 1'b0, logic [15:0] tg = '0);
    int gap;
    if (!stall_busy && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= op;
    immediate  <= imm;
    first_reg  <= r1;
    second_reg <= r2;
    from_queue <= fq;
    target     <= tg;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(execute_instr(op, imm, r1, r2, fq, tg));
    n_sent++;
  endtask

  function automatic logic [4:0] any_reg();
    return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                       : 5'($urandom_range(0, 25));
  endfunction

  function automatic logic [15:0] any_val();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 9));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_instr(qme_pkg::OpAdd);
    send_instr(qme_pkg::OpStore, '0, 5'd31);
    send_instr(qme_pkg::OpPrintNum, '0, '0, '0, 1'b1);
    send_instr(qme_pkg::OpPush, 16'hffff);
    send_instr(qme_pkg::OpPush, 16'hffff);
    send_instr(qme_pkg::OpMul);
    send_instr(qme_pkg::OpStore, '0, 5'd25);
    send_instr(qme_pkg::OpPrintNum, '0, 5'd25);
    send_instr(qme_pkg::OpPrintChr, '0, 5'd25);
    send_instr(qme_pkg::OpPush, 16'd0);
    send_instr(qme_pkg::OpPush, 16'd7);
    send_instr(qme_pkg::OpDiv);
    send_instr(qme_pkg::OpPush, 16'd0);
    send_instr(qme_pkg::OpPush, 16'd9);
    send_instr(qme_pkg::OpMod);
    send_instr(qme_pkg::OpSub);
    send_instr(qme_pkg::OpLoad, '0, 5'd25);
    send_instr(qme_pkg::OpPrintChr, '0, '0, '0, 1'b1);
    send_instr(qme_pkg::OpNop, 16'hffff, 5'd31, 5'd31, 1'b1, 16'hffff);
    send_instr(qme_pkg::OpJump, '0, '0, '0, '0, 16'hffff);
    send_instr(qme_pkg::OpJz, '0, 5'd0, '0, '0, 16'h8001);
    send_instr(qme_pkg::OpJe, '0, 5'd25, 5'd30, '0, 16'h1234);
    send_instr(qme_pkg::OpJg, '0, 5'd25, 5'd0, '0, 16'h4321);
    send_instr(qme_pkg::OpJg, '0, 5'd0, 5'd25, '0, 16'h4321);
    send_instr(qme_pkg::OpQuit);
  endtask

  task automatic test_queue_full();
    repeat (qme_pkg::QueueDepth + 3) send_instr(qme_pkg::OpPush, 16'($urandom));
    send_instr(qme_pkg::OpLoad, '0, 5'd25);
    send_instr(qme_pkg::OpAdd);
    send_instr(qme_pkg::OpPush, 16'h1);
    repeat (8) send_instr(qme_pkg::OpPrintNum, '0, '0, '0, 1'b1);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned  k;
    qme_pkg::op_e op;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 3) != 0) begin
        // well-formed run: operands, compute, store or print, branch
        send_instr(qme_pkg::OpPush, any_val());
        send_instr(qme_pkg::OpPush, any_val());
        send_instr(qme_pkg::op_e'($urandom_range(qme_pkg::OpAdd, qme_pkg::OpMod)));
        if ($urandom_range(0, 1)) send_instr(qme_pkg::OpStore, '0, any_reg());
        else send_instr(qme_pkg::op_e'($urandom_range(qme_pkg::OpPrintNum,
                                                      qme_pkg::OpPrintChr)),
                        '0, '0, '0, 1'b1);
        send_instr(qme_pkg::op_e'($urandom_range(qme_pkg::OpJump, qme_pkg::OpJg)),
                   '0, any_reg(), any_reg(), '0, 16'($urandom));
        k += 5;
      end else begin
        op = qme_pkg::op_e'($urandom_range(0, 15));
        send_instr(op, 16'($urandom), any_reg(), any_reg(), 1'($urandom), 16'($urandom));
        k++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 3) != 0) || (cycles[9:7] == 3'd0);
    cycles++;
    if (out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at cycle %0d", cycles);
      end else begin
        exec_res_t e, g;
        e = expected_q.pop_front();
        g = '{print_kind, print_value, branch_taken, branch_target, halt, status};
        n_results++;
        if (g !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch #%0d: kind %0d/%0d val %h/%h taken %b/%b",
                      " tgt %h/%h halt %b/%b st %0d/%0d"},
                     n_results, e.kind, g.kind, e.pval, g.pval, e.taken, g.taken,
                     e.tgt, g.tgt, e.halt, g.halt, e.st, g.st);
        end
      end
    end
    if (cycles > 400000) begin
      $display("queue_machine_execute_core verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned waited;
    rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0;
    mode = '0; immediate = '0; first_reg = '0; second_reg = '0;
    from_queue = 1'b0; target = '0;
    mismatches = 0; n_results = 0; n_sent = 0; cycles = 0; stall_busy = 0;
    foreach (regs_m[i]) regs_m[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    stall_busy = 1;
    test_random(150);
    stall_busy = 0;
    test_random(150);
    test_queue_full();
    in_valid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    $display("covered directed corner cases, random programs under sender gaps and");
    $display("receiver stalls, and queue fill to overflow: %0d sent, %0d checked",
             n_sent, n_results);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("queue_machine_execute_core verification clean");
    else
      $display("queue_machine_execute_core verification failed");
    $finish;
  end

endmodule
